// File: sv/prc_pkg.sv
// Shared types and constants for the precision/recall curve sweep.
`default_nettype none
package prc_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W = 32;
    localparam int CNT_W = 7;
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        TAG_TP = 2'd0,
        TAG_FP = 2'd1,
        TAG_FN = 2'd2,
        TAG_BAD = 2'd3
    } t_tag;

    typedef struct packed {
        logic signed [31:0] score;
        logic [1:0] truth_tag;
        logic last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] threshold;
        logic [6:0] tp_count;
        logic [6:0] fp_count;
        logic [6:0] fn_count;
        logic [16:0] precision_frac;
        logic [16:0] recall_frac;
        logic last_row;
    } t_out_item;

    // Negation that maps the most negative value to the most positive one.
    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
        logic signed [31:0] r;
        if (x == 32'sh80000000) begin
            r = 32'sh7FFFFFFF;
        end else begin
            r = -x;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/prc_cell.sv
// One sorting cell: holds one entry of the sorted chain and shifts or inserts.
`default_nettype none
module prc_cell
    import prc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_shift,
    input  wire logic        i_ins_valid,
    input  wire logic [33:0] i_ins,
    input  wire logic        i_left_lt,
    input  wire logic        i_left_valid,
    input  wire logic [33:0] i_left_data,
    input  wire logic        i_right_valid,
    input  wire logic [33:0] i_right_data,
    output logic             o_lt,
    output logic             o_valid,
    output logic [33:0]      o_data
);
    logic        r_valid;
    logic [33:0] r_data;
    logic        w_lt;

    // The new entry goes before this one: empty cell, or smaller score then tag.
    assign w_lt = !r_valid ||
                  ($signed(i_ins[33:2]) < $signed(r_data[33:2])) ||
                  ((i_ins[33:2] == r_data[33:2]) && (i_ins[1:0] < r_data[1:0]));

    // Insert: when the left cell also goes after the new entry, take the left
    // entry; otherwise take the new entry where it belongs. Shift: take the
    // right neighbor's entry so the chain moves toward the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_right_valid;
            r_data <= i_right_data;
        end else if (i_ins_valid) begin
            if (i_left_lt) begin
                r_valid <= i_left_valid;
                r_data <= i_left_data;
            end else if (w_lt) begin
                r_valid <= 1'b1;
                r_data <= i_ins;
            end
        end
    end

    assign o_lt = w_lt;
    assign o_valid = r_valid;
    assign o_data = r_data;
endmodule
`default_nettype wire

// File: sv/prc_div.sv
// Restoring divider for Q1.16 fractions, one quotient bit per cycle.
`default_nettype none
module prc_div
    import prc_pkg::*;
#(
    parameter int NUM_W = CNT_W,
    parameter int DEN_W = CNT_W + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_busy,
    output logic [FRAC_W-1:0]      o_quot
);
    localparam int FB = FRAC_W - 1;
    localparam int STEPS = NUM_W + FB;
    localparam int SW = $clog2(STEPS + 1);

    logic [SW-1:0]     r_cnt;
    logic [STEPS-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [FRAC_W-1:0] r_quot;
    logic [DEN_W:0]    w_trial;

    assign w_trial = {r_rem, r_num[STEPS-1]};

    // Shift the numerator in one bit a cycle and subtract where it fits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= SW'(STEPS);
            r_num <= {i_num, {FB{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - SW'(1);
            r_num <= {r_num[STEPS-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= DEN_W'(w_trial - {1'b0, r_den});
                r_quot <= {r_quot[FRAC_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_quot <= {r_quot[FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: sv/precision_recall_curve_sweep.sv
// Top level: insertion-sort cell chain, sweep sequencer and result register.
// Loading: one item per cycle; an item with a valid tag is sorted into the chain as it
// is taken, while it has room. After the last item: a count state, then peek and step
// per stored entry and divide and output per emitted row, the two 23-step dividers
// running side by side; output stalls hold the sweep. Input is not taken while a sweep
// runs. Synchronous active-low reset clears the chain, counts, sequencer and reverse_order.
`default_nettype none
module precision_recall_curve_sweep
    import prc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic     i_cfg_data
);
    localparam int NW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_COUNT = 6'b000010,
        S_PEEK  = 6'b000100,
        S_DIV   = 6'b001000,
        S_OUT   = 6'b010000,
        S_STEP  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic r_rev;
    logic [NW-1:0] r_n, r_left;
    logic [NW-1:0] r_tp, r_fp, r_fn;
    logic signed [31:0] r_prev;
    logic r_first;

    logic w_acc, w_shift, w_ins_valid;
    logic [33:0] w_ins;
    logic [CAPACITY+1:0] w_cv;
    logic [33:0] w_cd [CAPACITY+2];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_llt;
    logic signed [31:0] w_key;
    logic w_store;
    logic signed [31:0] w_hkey;
    logic [1:0] w_htag;
    logic r_dstart;
    logic w_pbusy, w_rbusy;
    logic [FRAC_W-1:0] w_pq, w_rq;
    logic [NW:0] w_pden, w_rden;

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == S_LOAD);
    assign w_acc = i_valid && o_ready;

    // Entry key, negated when lower scores are better.
    assign w_key = r_rev ? neg_sat(i_item.score) : i_item.score;
    assign w_store = (i_item.truth_tag != TAG_BAD) && (r_n < NW'(CAPACITY));
    assign w_ins_valid = w_acc && w_store;
    assign w_ins = {w_key, i_item.truth_tag};

    assign w_shift = (r_state == S_STEP);

    // Padding around the chain: nothing left of the head, nothing right of the tail.
    assign w_cv[0] = 1'b0;
    assign w_cv[CAPACITY+1] = 1'b0;
    assign w_cd[0] = '0;
    assign w_cd[CAPACITY+1] = '0;
    assign w_llt = {w_lt[CAPACITY-2:0], 1'b0};

    // Chain of sorting cells; cell 0 holds the smallest entry. Cell g shows up
    // at index g+1 of the padded valid and data arrays.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        prc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_shift),
            .i_ins_valid  (w_ins_valid),
            .i_ins        (w_ins),
            .i_left_lt    (w_llt[g]),
            .i_left_valid (w_cv[g]),
            .i_left_data  (w_cd[g]),
            .i_right_valid(w_cv[g+2]),
            .i_right_data (w_cd[g+2]),
            .o_lt         (w_lt[g]),
            .o_valid      (w_cv[g+1]),
            .o_data       (w_cd[g+1])
        );
    end

    assign w_hkey = $signed(w_cd[1][33:2]);
    assign w_htag = w_cd[1][1:0];

    // Dividers for precision and recall.
    assign w_pden = {1'b0, r_tp} + {1'b0, r_fp};
    assign w_rden = {1'b0, r_tp} + {1'b0, r_fn};

    prc_div #(.NUM_W(NW), .DEN_W(NW + 1)) u_pdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_tp), .i_den(w_pden), .o_busy(w_pbusy), .o_quot(w_pq)
    );
    prc_div #(.NUM_W(NW), .DEN_W(NW + 1)) u_rdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_tp), .i_den(w_rden), .o_busy(w_rbusy), .o_quot(w_rq)
    );

    // The row is last when no later stored entry has a different key.
    function automatic logic last_row_f();
        logic l;
        l = 1'b1;
        for (int k = 2; k <= CAPACITY; k++) begin
            if (w_cv[k] && w_cd[k][33:2] != w_cd[1][33:2]) l = 1'b0;
        end
        return l;
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (w_acc && i_item.last_item) n_state = S_COUNT;
            S_COUNT: n_state = (r_n == '0) ? S_LOAD : S_PEEK;
            S_PEEK:  n_state = (r_first || w_hkey != r_prev) ? S_DIV : S_STEP;
            S_DIV:   if (!r_dstart && !w_pbusy && !w_rbusy) n_state = S_OUT;
            S_OUT:   if (!o_valid || i_ready) n_state = S_STEP;
            S_STEP:  n_state = (r_left == NW'(1)) ? S_LOAD : S_PEEK;
            default: n_state = S_LOAD;
        endcase
    end

    // Sequencer, tag counts and the output register that holds one row until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rev <= 1'b0;
            r_n <= '0;
            r_tp <= '0;
            r_fp <= '0;
            r_fn <= '0;
            o_valid <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dstart <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (i_cfg_valid) r_rev <= i_cfg_data;
            unique case (r_state)
                S_LOAD: begin
                    r_first <= 1'b1;
                    if (w_ins_valid) begin
                        r_n <= r_n + NW'(1);
                        if (i_item.truth_tag == TAG_TP) begin
                            r_tp <= r_tp + NW'(1);
                        end else if (i_item.truth_tag == TAG_FP) begin
                            r_fp <= r_fp + NW'(1);
                        end else begin
                            r_fn <= r_fn + NW'(1);
                        end
                    end
                end
                S_COUNT: begin
                    r_left <= r_n;
                    r_n <= '0;
                end
                S_PEEK: if (r_first || w_hkey != r_prev) r_dstart <= 1'b1;
                S_DIV: ;
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_item.threshold <= r_rev ? neg_sat(w_hkey) : w_hkey;
                        o_item.tp_count <= CNT_W'(r_tp);
                        o_item.fp_count <= CNT_W'(r_fp);
                        o_item.fn_count <= CNT_W'(r_fn);
                        o_item.precision_frac <= (w_pden == '0) ? ONE_Q16 : w_pq;
                        o_item.recall_frac <= (w_rden == '0) ? '0 : w_rq;
                        o_item.last_row <= last_row_f();
                    end
                end
                S_STEP: begin
                    r_first <= 1'b0;
                    r_prev <= w_hkey;
                    r_left <= r_left - NW'(1);
                    // The set is done after its final entry: counts start over.
                    if (r_left == NW'(1)) begin
                        r_tp <= '0;
                        r_fp <= '0;
                        r_fn <= '0;
                    end else if (w_htag == TAG_TP) begin
                        r_tp <= r_tp - NW'(1);
                        r_fn <= r_fn + NW'(1);
                    end else if (w_htag == TAG_FP) begin
                        r_fp <= r_fp - NW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/prc_checker.sv
// Port-level checker for the precision/recall curve sweep, bound to the top.
`default_nettype none
module prc_checker
    import prc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_ready,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_item
);
    // A stalled row holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item)) else $error("row changed");
    // Fractions never exceed one.
    a_prec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.precision_frac <= ONE_Q16) else $error("precision range");
    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.recall_frac <= ONE_Q16) else $error("recall range");
    // Handshake outputs are always driven out of reset.
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_ready})) else $error("handshake unknown");
    // Reset leaves no row pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("row after reset");
endmodule

bind precision_recall_curve_sweep prc_checker u_prc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
);
`default_nettype wire
